// File: design/chd_pkg.sv
// Shared types, constants and helper functions of the chained hash dedup table.
package chd_pkg;

    // Table geometry (both counts are powers of two)
    localparam int ENTRY_COUNT  = 1024;
    localparam int BUCKET_COUNT = 256;
    localparam int REF_BITS     = 16;
    localparam int FOLD_MUL     = 131;
    localparam int DIGEST_WORDS = 4;
    localparam int WORD_BYTES   = 8;
    localparam int FOUND_W      = 10;

    localparam int IDX_W   = $clog2(ENTRY_COUNT);
    localparam int LINK_W  = $clog2(ENTRY_COUNT + 1);
    localparam int BKT_W   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int SWEEP   = (ENTRY_COUNT > BUCKET_COUNT) ? ENTRY_COUNT : BUCKET_COUNT;
    localparam int SWEEP_W = $clog2(SWEEP);
    localparam int CNT_W   = $clog2(DIGEST_WORDS);

    localparam logic [LINK_W-1:0]   NIL_LINK = LINK_W'(ENTRY_COUNT);
    localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};

    // Operation codes
    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_INC    = 3'd3;
    localparam logic [2:0] OP_DEC    = 3'd4;

    // Status codes
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REFERENCED = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] digest_word0;
        logic [63:0] digest_word1;
        logic [63:0] digest_word2;
        logic [63:0] digest_word3;
        logic [63:0] node_value;
        logic [10:0] ref_entry;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [FOUND_W-1:0] found_entry;
        logic [63:0]        stored_value;
        logic               entry_freed;
    } t_out;

    typedef struct packed {
        logic [LINK_W-1:0]   next;
        logic [IDX_W-1:0]    key;
        logic [REF_BITS-1:0] count;
        logic [63:0]         value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef logic [DIGEST_WORDS-1:0][63:0] t_digest;

    // Fold one 64-bit digest word into the key, first byte most significant
    function automatic logic [IDX_W-1:0] f_fold_word(logic [IDX_W-1:0] h_in,
                                                     logic [63:0] word);
        int unsigned acc;
        logic [7:0]  bt;
        acc = 32'(h_in);
        for (int b = WORD_BYTES - 1; b >= 0; b--) begin
            bt  = word[b*8 +: 8];
            acc = (acc * FOLD_MUL + 32'(bt)) % ENTRY_COUNT;
        end
        return IDX_W'(acc);
    endfunction

    // Bucket of a key
    function automatic logic [BKT_W-1:0] f_bucket(logic [IDX_W-1:0] key);
        return BKT_W'(32'(key) % BUCKET_COUNT);
    endfunction

endpackage

// File: design/chd_ram.sv
// Generic single-port-write, registered-read RAM.
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/chd_fold.sv
// Digest-to-key folding unit, one 64-bit digest word per cycle.
module chd_fold (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  chd_pkg::t_digest         i_words,
    output logic                     o_done,
    output logic [chd_pkg::IDX_W-1:0] o_key
);
    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [chd_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [chd_pkg::IDX_W-1:0]    r_h, n_h;

    // Advance the fold by one word per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_h    = r_h;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_h    = '0;
        end else if (r_busy) begin
            n_h   = chd_pkg::f_fold_word(r_h, i_words[r_cnt]);
            n_cnt = r_cnt + 1'b1;
            if (32'(r_cnt) == chd_pkg::DIGEST_WORDS - 1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_h   <= n_h;
    end

    assign o_done = r_done;
    assign o_key  = r_h;
endmodule

// File: design/chained_hash_dedup_table.sv
// Top level: chained hash table with free list and reference counts.
//
// After reset the block sweeps every address of its entry and bucket
// memories with busy high. An item is taken when start is high and busy is
// low; its single result appears on o_result for one cycle with o_strobe,
// and the receiver cannot stall it. Key operations (lookup, insert, remove)
// fold the digest, read the bucket head, then visit the chain entries one by
// one through the entry memory read port, decide and write back, and
// register the result. Reference operations read and update the count, and
// a decrease that frees its entry adds a chain walk by identity. Bad codes
// and out-of-range entries are answered straight from idle. A new item can
// be taken in the cycle that carries the previous result.
module chained_hash_dedup_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  chd_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_strobe,
    output chd_pkg::t_out o_result
);
    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_HASH   = 10'b00_0000_0100,
        S_HEAD   = 10'b00_0000_1000,
        S_WALK   = 10'b00_0001_0000,
        S_DECIDE = 10'b00_0010_0000,
        S_REF    = 10'b00_0100_0000,
        S_ALLOC  = 10'b00_1000_0000,
        S_UNLINK = 10'b01_0000_0000,
        S_FREE   = 10'b10_0000_0000
    } t_state;

    localparam int IW = chd_pkg::IDX_W;
    localparam int LW = chd_pkg::LINK_W;
    localparam int BW = chd_pkg::BKT_W;

    localparam logic [chd_pkg::REF_BITS-1:0] REF_BITS_ONE =
        {{(chd_pkg::REF_BITS-1){1'b0}}, 1'b1};

    t_state                      r_state, n_state;
    chd_pkg::t_in                r_item, n_item;
    logic [IW-1:0]               r_key, n_key;
    logic [IW-1:0]               r_target, n_target;
    logic [BW-1:0]               r_bkt, n_bkt;
    logic                        r_by_key, n_by_key;
    logic                        r_hit, n_hit;
    logic [LW-1:0]               r_cur, n_cur;
    logic [LW-1:0]               r_prev, n_prev;
    logic [LW-1:0]               r_head, n_head;
    logic [LW-1:0]               r_steps, n_steps;
    logic [LW-1:0]               r_free_head, n_free_head;
    logic [chd_pkg::SWEEP_W-1:0] r_sweep, n_sweep;
    chd_pkg::t_entry             r_cur_word, n_cur_word;
    chd_pkg::t_entry             r_prev_word, n_prev_word;
    chd_pkg::t_out               r_out, n_out;
    logic                        r_strobe, n_strobe;

    logic                 e_we;
    logic [IW-1:0]        e_waddr, e_raddr;
    chd_pkg::t_entry      e_wdata, e_q;
    logic                 b_we;
    logic [BW-1:0]        b_waddr, b_raddr;
    logic [LW-1:0]        b_wdata, b_q;

    logic                 fold_start, fold_done;
    logic [IW-1:0]        fold_key;
    chd_pkg::t_digest     w_words;
    logic                 w_match;
    logic [LW-1:0]        w_steps_inc;

    assign w_words = {r_item.digest_word3, r_item.digest_word2,
                      r_item.digest_word1, r_item.digest_word0};

    chd_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fold_start),
        .i_words (w_words),
        .o_done  (fold_done),
        .o_key   (fold_key)
    );

    chd_ram #(.WIDTH(chd_pkg::ENTRY_W), .DEPTH(chd_pkg::ENTRY_COUNT)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_q)
    );

    chd_ram #(.WIDTH(LW), .DEPTH(chd_pkg::BUCKET_COUNT)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_q)
    );

    assign w_match     = r_by_key ? (e_q.key == r_key) : (r_cur[IW-1:0] == r_target);
    assign w_steps_inc = r_steps + 1'b1;

    // Sequence one operation through the memories
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_key       = r_key;
        n_target    = r_target;
        n_bkt       = r_bkt;
        n_by_key    = r_by_key;
        n_hit       = r_hit;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_head      = r_head;
        n_steps     = r_steps;
        n_free_head = r_free_head;
        n_sweep     = r_sweep;
        n_cur_word  = r_cur_word;
        n_prev_word = r_prev_word;
        n_out       = r_out;
        n_strobe    = 1'b0;
        fold_start  = 1'b0;
        e_we        = 1'b0;
        e_waddr     = r_cur[IW-1:0];
        e_wdata     = r_cur_word;
        e_raddr     = r_cur[IW-1:0];
        b_we        = 1'b0;
        b_waddr     = r_bkt;
        b_wdata     = chd_pkg::NIL_LINK;
        b_raddr     = r_bkt;

        case (r_state)
            // Sweep the memories to their reset contents
            S_CLEAR: begin
                if (32'(r_sweep) < chd_pkg::ENTRY_COUNT) begin
                    e_we          = 1'b1;
                    e_waddr       = IW'(r_sweep);
                    e_wdata       = '0;
                    e_wdata.next  = LW'(r_sweep) + 1'b1;
                end
                if (32'(r_sweep) < chd_pkg::BUCKET_COUNT) begin
                    b_we    = 1'b1;
                    b_waddr = BW'(r_sweep);
                end
                n_sweep = r_sweep + 1'b1;
                if (32'(r_sweep) == chd_pkg::SWEEP - 1) begin
                    n_state = S_IDLE;
                end
            end

            // Take a beat and dispatch on its operation
            S_IDLE: begin
                if (start) begin
                    n_item   = i_item;
                    n_target = IW'(i_item.ref_entry);
                    n_out    = '0;
                    case (i_item.op)
                        chd_pkg::OP_LOOKUP, chd_pkg::OP_INSERT, chd_pkg::OP_REMOVE: begin
                            fold_start = 1'b1;
                            n_by_key   = 1'b1;
                            n_state    = S_HASH;
                        end
                        chd_pkg::OP_INC, chd_pkg::OP_DEC: begin
                            n_by_key = 1'b0;
                            if (32'(i_item.ref_entry) >= chd_pkg::ENTRY_COUNT) begin
                                n_out.status = chd_pkg::ST_IGNORED;
                                n_strobe     = 1'b1;
                            end else begin
                                e_raddr = IW'(i_item.ref_entry);
                                n_state = S_REF;
                            end
                        end
                        default: begin
                            n_out.status = chd_pkg::ST_IGNORED;
                            n_strobe     = 1'b1;
                        end
                    endcase
                end
            end

            // Hold until the key is folded, then read the bucket head
            S_HASH: begin
                if (fold_done) begin
                    n_key   = fold_key;
                    n_bkt   = chd_pkg::f_bucket(fold_key);
                    b_raddr = chd_pkg::f_bucket(fold_key);
                    n_state = S_HEAD;
                end
            end

            // Start the chain walk at the bucket head
            S_HEAD: begin
                n_head  = b_q;
                n_prev  = chd_pkg::NIL_LINK;
                n_steps = '0;
                n_cur   = b_q;
                if (32'(b_q) < chd_pkg::ENTRY_COUNT) begin
                    e_raddr = b_q[IW-1:0];
                    n_state = S_WALK;
                end else begin
                    n_hit   = 1'b0;
                    n_state = S_DECIDE;
                end
            end

            // Compare one chain entry, advance to the next
            S_WALK: begin
                if (w_match) begin
                    n_hit      = 1'b1;
                    n_cur_word = e_q;
                    n_state    = S_DECIDE;
                end else begin
                    n_prev      = r_cur;
                    n_prev_word = e_q;
                    n_cur       = e_q.next;
                    n_steps     = w_steps_inc;
                    if (32'(e_q.next) < chd_pkg::ENTRY_COUNT &&
                        32'(w_steps_inc) < chd_pkg::ENTRY_COUNT) begin
                        e_raddr = e_q.next[IW-1:0];
                    end else begin
                        n_hit   = 1'b0;
                        n_state = S_DECIDE;
                    end
                end
            end

            // Act on the walk outcome
            S_DECIDE: begin
                n_state = S_IDLE;
                case (r_item.op)
                    chd_pkg::OP_LOOKUP: begin
                        n_strobe = 1'b1;
                        if (r_hit) begin
                            n_out.status       = chd_pkg::ST_DONE;
                            n_out.found_entry  = chd_pkg::FOUND_W'(r_cur);
                            n_out.stored_value = r_cur_word.value;
                        end else begin
                            n_out.status = chd_pkg::ST_NOT_FOUND;
                        end
                    end
                    chd_pkg::OP_INSERT: begin
                        if (r_hit) begin
                            n_strobe          = 1'b1;
                            n_out.status      = chd_pkg::ST_PRESENT;
                            n_out.found_entry = chd_pkg::FOUND_W'(r_cur);
                        end else if (32'(r_free_head) >= chd_pkg::ENTRY_COUNT) begin
                            n_strobe     = 1'b1;
                            n_out.status = chd_pkg::ST_FULL;
                        end else begin
                            e_raddr = r_free_head[IW-1:0];
                            n_state = S_ALLOC;
                        end
                    end
                    chd_pkg::OP_REMOVE: begin
                        if (!r_hit) begin
                            n_strobe     = 1'b1;
                            n_out.status = chd_pkg::ST_NOT_FOUND;
                        end else if (r_cur_word.count != '0) begin
                            n_strobe     = 1'b1;
                            n_out.status = chd_pkg::ST_REFERENCED;
                        end else begin
                            n_state = S_UNLINK;
                        end
                    end
                    default: begin
                        // decrease that reached zero
                        if (r_hit) begin
                            n_state = S_UNLINK;
                        end else begin
                            n_strobe     = 1'b1;
                            n_out.status = chd_pkg::ST_DONE;
                        end
                    end
                endcase
            end

            // Update a reference count
            S_REF: begin
                n_state      = S_IDLE;
                n_strobe     = 1'b1;
                n_out.status = chd_pkg::ST_DONE;
                e_waddr      = r_target;
                e_wdata      = e_q;
                if (r_item.op == chd_pkg::OP_INC) begin
                    if (e_q.count != chd_pkg::REF_MAX) begin
                        e_we          = 1'b1;
                        e_wdata.count = e_q.count + 1'b1;
                    end
                end else if (e_q.count == '0) begin
                    n_out.status = chd_pkg::ST_IGNORED;
                end else begin
                    e_we          = 1'b1;
                    e_wdata.count = e_q.count - 1'b1;
                    if (e_q.count == REF_BITS_ONE) begin
                        n_strobe = 1'b0;
                        n_bkt    = chd_pkg::f_bucket(e_q.key);
                        b_raddr  = chd_pkg::f_bucket(e_q.key);
                        n_state  = S_HEAD;
                    end
                end
            end

            // Pop the free list and link the new entry at the bucket head
            S_ALLOC: begin
                n_free_head       = e_q.next;
                e_we              = 1'b1;
                e_waddr           = r_free_head[IW-1:0];
                e_wdata.next      = r_head;
                e_wdata.key       = r_key;
                e_wdata.count     = REF_BITS_ONE;
                e_wdata.value     = r_item.node_value;
                b_we              = 1'b1;
                b_wdata           = r_free_head;
                n_strobe          = 1'b1;
                n_out.status      = chd_pkg::ST_DONE;
                n_out.found_entry = chd_pkg::FOUND_W'(r_free_head);
                n_state           = S_IDLE;
            end

            // Drop the entry from its chain
            S_UNLINK: begin
                if (r_prev == chd_pkg::NIL_LINK) begin
                    b_we    = 1'b1;
                    b_wdata = r_cur_word.next;
                end else begin
                    e_we         = 1'b1;
                    e_waddr      = r_prev[IW-1:0];
                    e_wdata      = r_prev_word;
                    e_wdata.next = r_cur_word.next;
                end
                n_state = S_FREE;
            end

            // Push the entry onto the free list
            S_FREE: begin
                e_we              = 1'b1;
                e_wdata.next      = r_free_head;
                n_free_head       = r_cur;
                n_strobe          = 1'b1;
                n_out.status      = chd_pkg::ST_DONE;
                n_out.entry_freed = (r_item.op == chd_pkg::OP_DEC);
                n_state           = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_free_head <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_free_head <= n_free_head;
            r_strobe    <= n_strobe;
        end
        r_item      <= n_item;
        r_key       <= n_key;
        r_target    <= n_target;
        r_bkt       <= n_bkt;
        r_by_key    <= n_by_key;
        r_hit       <= n_hit;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_head      <= n_head;
        r_steps     <= n_steps;
        r_cur_word  <= n_cur_word;
        r_prev_word <= n_prev_word;
        r_out       <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // Checks on the sequencer
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe || $past(start && !busy))
        else $error("result strobe repeated without a new item");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_state == S_IDLE)
        else $error("result issued while still working");
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free_head) <= chd_pkg::ENTRY_COUNT)
        else $error("free list head out of range");
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> busy && !o_strobe)
        else $error("activity during memory sweep");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> 32'(r_cur) < chd_pkg::ENTRY_COUNT)
        else $error("chain walk on a null link");
endmodule

// File: verif/chained_hash_dedup_table_tb.sv
// Testbench for the chained hash dedup table: directed and random operations checked against a local table model.
`timescale 1ns / 100ps

module chained_hash_dedup_table_tb;

    localparam int NIL = chd_pkg::ENTRY_COUNT;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    chd_pkg::t_in   i_item;
    logic           busy;
    logic           o_strobe;
    chd_pkg::t_out  o_result;

    chained_hash_dedup_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // Table model state
    int unsigned    head_of[chd_pkg::BUCKET_COUNT];
    int unsigned    link_of[chd_pkg::ENTRY_COUNT];
    int unsigned    key_of[chd_pkg::ENTRY_COUNT];
    longint unsigned refs_of[chd_pkg::ENTRY_COUNT];
    logic [63:0]    value_of[chd_pkg::ENTRY_COUNT];
    bit             ever_used[chd_pkg::ENTRY_COUNT];
    int unsigned    free_top;

    chd_pkg::t_in  pending_items[$];
    chd_pkg::t_out expected_results[$];
    int   error_count = 0;
    int   idle_pct = 0;
    logic busy_at_edge = 1'b1;

    // Clock generation
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic report(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic int unsigned digest_key(input chd_pkg::t_in it);
        logic [63:0] w[4];
        int unsigned h;
        h = 0;
        w[0] = it.digest_word0; w[1] = it.digest_word1;
        w[2] = it.digest_word2; w[3] = it.digest_word3;
        for (int k = 0; k < 4; k++)
            for (int b = 7; b >= 0; b--)
                h = (h * chd_pkg::FOLD_MUL + 32'(w[k][b*8 +: 8])) % chd_pkg::ENTRY_COUNT;
        return h;
    endfunction

    // Walk a chain by key or by identity; returns NIL when absent
    function automatic int unsigned chain_find(input int unsigned bkt, input bit by_key,
                                               input int unsigned target,
                                               output int unsigned prev);
        int unsigned cur;
        int unsigned steps;
        cur = head_of[bkt];
        prev = NIL;
        steps = 0;
        while (cur < NIL && steps < NIL) begin
            if (by_key ? (key_of[cur] == target) : (cur == target)) return cur;
            prev = cur;
            cur = link_of[cur];
            steps++;
        end
        prev = NIL;
        return NIL;
    endfunction

    function automatic void unlink_entry(input int unsigned bkt, input int unsigned prev,
                                         input int unsigned idx);
        if (prev == NIL) head_of[bkt] = link_of[idx];
        else link_of[prev] = link_of[idx];
        link_of[idx] = free_top;
        free_top = idx;
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < chd_pkg::BUCKET_COUNT; i++) head_of[i] = NIL;
        for (int i = 0; i < chd_pkg::ENTRY_COUNT; i++) begin
            link_of[i] = i + 1;
            key_of[i] = 0;
            refs_of[i] = 0;
            value_of[i] = '0;
            ever_used[i] = 0;
        end
        free_top = 0;
    endfunction

    // Apply one operation to the model and return its result
    function automatic chd_pkg::t_out table_apply(input chd_pkg::t_in it);
        chd_pkg::t_out r;
        int unsigned key, bkt, idx, prev;
        r = '0;
        r.status = chd_pkg::ST_IGNORED;
        if (it.op == chd_pkg::OP_LOOKUP || it.op == chd_pkg::OP_INSERT ||
            it.op == chd_pkg::OP_REMOVE) begin
            key = digest_key(it);
            bkt = key % chd_pkg::BUCKET_COUNT;
            idx = chain_find(bkt, 1, key, prev);
            if (it.op == chd_pkg::OP_LOOKUP) begin
                if (idx != NIL) begin
                    r.status = chd_pkg::ST_DONE;
                    r.found_entry = chd_pkg::FOUND_W'(idx);
                    r.stored_value = value_of[idx];
                end else r.status = chd_pkg::ST_NOT_FOUND;
            end else if (it.op == chd_pkg::OP_INSERT) begin
                if (idx != NIL) begin
                    r.status = chd_pkg::ST_PRESENT;
                    r.found_entry = chd_pkg::FOUND_W'(idx);
                end else if (free_top >= NIL) begin
                    r.status = chd_pkg::ST_FULL;
                end else begin
                    idx = free_top;
                    free_top = link_of[idx];
                    key_of[idx] = key;
                    value_of[idx] = it.node_value;
                    refs_of[idx] = 1;
                    ever_used[idx] = 1;
                    link_of[idx] = head_of[bkt];
                    head_of[bkt] = idx;
                    r.status = chd_pkg::ST_DONE;
                    r.found_entry = chd_pkg::FOUND_W'(idx);
                end
            end else begin
                if (idx == NIL) r.status = chd_pkg::ST_NOT_FOUND;
                else if (refs_of[idx] > 0) r.status = chd_pkg::ST_REFERENCED;
                else begin
                    unlink_entry(bkt, prev, idx);
                    r.status = chd_pkg::ST_DONE;
                end
            end
        end else if ((it.op == chd_pkg::OP_INC || it.op == chd_pkg::OP_DEC) &&
                     32'(it.ref_entry) < chd_pkg::ENTRY_COUNT) begin
            idx = 32'(it.ref_entry);
            if (it.op == chd_pkg::OP_INC) begin
                if (refs_of[idx] < 64'(chd_pkg::REF_MAX)) refs_of[idx]++;
                r.status = chd_pkg::ST_DONE;
            end else if (refs_of[idx] != 0) begin
                refs_of[idx]--;
                r.status = chd_pkg::ST_DONE;
                if (refs_of[idx] == 0) begin
                    bkt = key_of[idx] % chd_pkg::BUCKET_COUNT;
                    if (chain_find(bkt, 0, idx, prev) != NIL) begin
                        unlink_entry(bkt, prev, idx);
                        r.entry_freed = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // Driver: present the next beat at the falling edge, advance after acceptance
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy_at_edge) begin
            // previous beat was taken at the last rising edge
            if (pending_items.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (pending_items.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
            end
        end
    end

    // Track acceptance and predict at the accepting edge
    always @(posedge i_clk) begin
        busy_at_edge <= busy;
        if (i_rst_n && start && !busy) expected_results.push_back(table_apply(i_item));
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        chd_pkg::t_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report("result beat with no expectation");
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status)
                    report($sformatf("status %0d, expected %0d", o_result.status, want.status));
                if (o_result.found_entry !== want.found_entry)
                    report($sformatf("found_entry %0d, expected %0d",
                                     o_result.found_entry, want.found_entry));
                if (o_result.stored_value !== want.stored_value)
                    report($sformatf("stored_value %h, expected %h",
                                     o_result.stored_value, want.stored_value));
                if (o_result.entry_freed !== want.entry_freed)
                    report($sformatf("entry_freed %0b, expected %0b",
                                     o_result.entry_freed, want.entry_freed));
            end
        end
    end

    // Digests from a small pool, so keys repeat and chains grow
    logic [63:0] digest_pool[48][4];

    function automatic chd_pkg::t_in make_item(input logic [2:0] op, input int pick,
                                               input logic [10:0] idx);
        chd_pkg::t_in it;
        it.op = op;
        it.digest_word0 = digest_pool[pick][0];
        it.digest_word1 = digest_pool[pick][1];
        it.digest_word2 = digest_pool[pick][2];
        it.digest_word3 = digest_pool[pick][3];
        it.node_value = {$urandom, $urandom};
        it.ref_entry = idx;
        return it;
    endfunction

    // Last digest word that folds to key k when all earlier bytes are zero
    function automatic logic [63:0] key_word(input int unsigned k);
        int unsigned hi, lo;
        bit          got;
        hi = 0;
        lo = 0;
        got = 0;
        for (int b = 0; b < 8; b++) begin
            if (!got) begin
                lo = (k + 8 * chd_pkg::ENTRY_COUNT - chd_pkg::FOLD_MUL * b)
                     % chd_pkg::ENTRY_COUNT;
                if (lo < 256) begin
                    hi = b;
                    got = 1;
                end
            end
        end
        return {48'd0, 8'(hi), 8'(lo)};
    endfunction

    // Wait until the queue drains and every expectation has come back
    task automatic drain();
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Entry for a reference operation: one that was inserted at some point, else out of range after 20 tries
    function automatic logic [10:0] used_index();
        int unsigned e;
        for (int tries = 0; tries < 20; tries++) begin
            e = $urandom_range(chd_pkg::ENTRY_COUNT - 1, 0);
            if (ever_used[e]) return 11'(e);
        end
        return 11'(chd_pkg::ENTRY_COUNT + $urandom_range(chd_pkg::ENTRY_COUNT - 1, 0));
    endfunction

    // Stimulus
    initial begin
        chd_pkg::t_in it;
        int  pick;
        int  roll;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        table_clear();
        for (int p = 0; p < 48; p++)
            for (int k = 0; k < 4; k++) digest_pool[p][k] = {$urandom, $urandom};
        for (int k = 0; k < 4; k++) begin
            digest_pool[0][k] = '0;
            digest_pool[1][k] = '1;
        end
        // Same bucket as the all-zero digest: last two bytes fold to key 256
        digest_pool[2] = digest_pool[0];
        digest_pool[2][3] = 64'h17D;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every op, the special cases
        pending_items.push_back(make_item(chd_pkg::OP_LOOKUP, 0, 0));      // miss
        pending_items.push_back(make_item(chd_pkg::OP_REMOVE, 0, 0));      // remove missing
        pending_items.push_back(make_item(chd_pkg::OP_INSERT, 0, 0));
        pending_items.push_back(make_item(chd_pkg::OP_INSERT, 1, 0));
        pending_items.push_back(make_item(chd_pkg::OP_INSERT, 2, 0));      // shares a bucket
        pending_items.push_back(make_item(chd_pkg::OP_INSERT, 0, 0));      // present
        pending_items.push_back(make_item(chd_pkg::OP_LOOKUP, 0, 0));
        pending_items.push_back(make_item(chd_pkg::OP_LOOKUP, 2, 0));
        pending_items.push_back(make_item(chd_pkg::OP_REMOVE, 0, 0));      // referenced
        pending_items.push_back(make_item(chd_pkg::OP_INC, 0, 11'd1));
        pending_items.push_back(make_item(chd_pkg::OP_DEC, 0, 11'd1));
        pending_items.push_back(make_item(chd_pkg::OP_DEC, 0, 11'd0));     // frees chain tail
        pending_items.push_back(make_item(chd_pkg::OP_DEC, 0, 11'd0));     // zero count
        pending_items.push_back(make_item(chd_pkg::OP_INC, 0, 11'd0));     // free entry count
        pending_items.push_back(make_item(chd_pkg::OP_DEC, 0, 11'd0));     // zero, not on chain
        pending_items.push_back(make_item(chd_pkg::OP_INC, 0, 11'd2047));  // out of range
        pending_items.push_back(make_item(chd_pkg::OP_DEC, 0, 11'd1024));
        pending_items.push_back(make_item(3'd5, 1, 11'd0));                // bad codes
        pending_items.push_back(make_item(3'd6, 1, 11'd0));
        pending_items.push_back(make_item(3'd7, 1, 11'd2047));
        pending_items.push_back(make_item(chd_pkg::OP_DEC, 2, 11'd2));     // frees chain head
        pending_items.push_back(make_item(chd_pkg::OP_REMOVE, 2, 0));      // gone already
        drain();

        // Random phases with varying sender idling
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 73 : (ph == 2) ? 0 : 23;
            for (int n = 0; n < 75; n++) begin
                pick = $urandom_range(47, 0);
                roll = $urandom_range(99, 0);
                if (roll < 30) it = make_item(chd_pkg::OP_INSERT, pick, 0);
                else if (roll < 50) it = make_item(chd_pkg::OP_LOOKUP, pick, 0);
                else if (roll < 60) it = make_item(chd_pkg::OP_REMOVE, pick, 0);
                else if (roll < 72) it = make_item(chd_pkg::OP_INC, pick, used_index());
                else if (roll < 92) it = make_item(chd_pkg::OP_DEC, pick, used_index());
                else begin
                    it = make_item(3'($urandom_range(7, 0)), pick,
                                   11'($urandom_range(2047, chd_pkg::ENTRY_COUNT)));
                    it.digest_word1 = {$urandom, $urandom};
                end
                pending_items.push_back(it);
                // keep the model ahead of issue for used_index
                if (pending_items.size() > 8) drain();
            end
            drain();
        end

        // Insert every key once: the free list runs dry and the chains grow
        idle_pct = 0;
        for (int n = 0; n < chd_pkg::ENTRY_COUNT; n++) begin
            it = make_item(chd_pkg::OP_INSERT, 0, 0);
            it.digest_word3 = key_word(n);
            pending_items.push_back(it);
        end
        drain();

        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit
    initial begin
        #60ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: filelist.f
design/chd_pkg.sv
design/chd_ram.sv
design/chd_fold.sv
design/chained_hash_dedup_table.sv
verif/chained_hash_dedup_table_tb.sv
